// File: design/fmp_pkg.sv
// ----------------------------------------------------------------------------
// fmp_pkg
// shared types and constants for the fibonacci matrix power block
// ----------------------------------------------------------------------------
package fmp_pkg;

  // field and bus widths
  localparam int INDEX_W    = 31;
  localparam int FIB_W      = 32;
  localparam int IN_TDATA_W = 32;
  localparam int OUT_TDATA_W = 32;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DBL,
    ST_ADV,
    ST_FINISH
  } state_t;

  // products of one doubling step, in the order they run
  typedef enum logic [1:0] {
    OP_CROSS,   // a * (2b - a)
    OP_SQ_A,    // a * a
    OP_SQ_B     // b * b, accumulated onto a * a
  } mul_op_t;

endpackage

// File: design/fibonacci_matrix_power.sv
// ----------------------------------------------------------------------------
// fibonacci_matrix_power
// n-th fibonacci number modulo 2^VALUE_BITS by repeated doubling
// ----------------------------------------------------------------------------
// Usage
//   s_* channel: one transaction carries an index n in s_tdata; one result
//   transaction on the m_* channel carries F(n), with F(0) = 0, F(1) = 1,
//   wrapped to VALUE_BITS bits and shown as a 32-bit two's complement value.
//   s_tready is high only while the sequencer is idle; one index is worked
//   on at a time.
//   The bits of n-1 are scanned from the top of INDEX_BITS bits down.  The
//   first set bit takes a scan step and an advance step; every later bit
//   takes a set-up step and a doubling step of three products on one shared
//   multiply-accumulate unit, each product worked digit by digit, plus an
//   advance step when the bit is set.  Leading zeros take one scan step
//   each.  Index zero goes from the accept state straight to finish.
//   The result waits in an output register; the next index is accepted
//   while it waits, and a finished result holds the sequencer until the
//   receiver has taken the previous one.
//   rst (synchronous) empties the output register and returns to idle.
// ----------------------------------------------------------------------------
module fibonacci_matrix_power #(
  parameter int VALUE_BITS = 32,
  parameter int INDEX_BITS = 31
) (
  input  logic                           clk,
  input  logic                           rst,
  // slave side
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [fmp_pkg::IN_TDATA_W-1:0]  s_tdata,   // [30:0] index, [31] zero pad
  // master side
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [fmp_pkg::OUT_TDATA_W-1:0] m_tdata    // [31:0] fib_value
);

  import fmp_pkg::*;

  // multiplier digit sizes
  localparam int DIGIT_BITS = (VALUE_BITS > 32) ? 16 : VALUE_BITS;
  localparam int NUM_DIGITS = (VALUE_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int PAD_BITS   = NUM_DIGITS * DIGIT_BITS;
  localparam int DIG_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int CNT_W      = $clog2(INDEX_BITS);

  state_t                  state, state_next;
  mul_op_t                 op;
  logic [DIG_W-1:0]        dig;
  logic [CNT_W-1:0]        cnt;
  logic [INDEX_BITS-1:0]   e;
  logic                    started;
  logic [VALUE_BITS-1:0]   fa, fb, tmp, s1, acc;

  logic [INDEX_BITS-1:0]   n_in;
  logic                    bit_now, last_bit, mul_last, step_adv;
  logic [VALUE_BITS-1:0]   mx, my;
  logic [PAD_BITS-1:0]     my_pad;
  logic [DIGIT_BITS-1:0]   digit;
  logic [VALUE_BITS+DIGIT_BITS-1:0] pp;
  logic [VALUE_BITS-1:0]   pp_low, sum;
  logic                    out_free;

  assign n_in     = INDEX_BITS'(s_tdata[INDEX_W-1:0]);
  assign bit_now  = e[INDEX_BITS-1];
  assign last_bit = (cnt == '0);
  assign mul_last = (dig == DIG_W'(NUM_DIGITS - 1));
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // shared multiply-accumulate unit, one digit of my per cycle
  always_comb begin
    case (op)
      OP_CROSS: begin
        mx = fa;
        my = tmp;
      end
      OP_SQ_A: begin
        mx = fa;
        my = fa;
      end
      default: begin
        mx = fb;
        my = fb;
      end
    endcase
  end

  assign my_pad = PAD_BITS'(my);
  assign digit  = my_pad[dig * DIGIT_BITS +: DIGIT_BITS];
  assign pp     = mx * digit;
  assign pp_low = pp[VALUE_BITS-1:0];
  assign sum    = acc + (pp_low << (dig * DIGIT_BITS));

  // end of one index bit: move on to the next bit
  assign step_adv = (state == ST_SCAN && !started && !bit_now)
                 || (state == ST_DBL && mul_last && op == OP_SQ_B && !bit_now)
                 || (state == ST_ADV);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (n_in == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (started) begin
          state_next = ST_DBL;
        end else if (bit_now) begin
          state_next = ST_ADV;
        end else if (last_bit) begin
          state_next = ST_FINISH;
        end
      end
      ST_DBL: begin
        if (mul_last && op == OP_SQ_B) begin
          if (bit_now) begin
            state_next = ST_ADV;
          end else begin
            state_next = last_bit ? ST_FINISH : ST_SCAN;
          end
        end
      end
      ST_ADV: begin
        state_next = last_bit ? ST_FINISH : ST_SCAN;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // output register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output data
  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      m_tdata <= OUT_TDATA_W'(FIB_W'(fb));
    end
  end

  // datapath: pair (fa, fb) = (F(k), F(k+1)) over the scanned prefix k
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      e       <= n_in - INDEX_BITS'(1);
      cnt     <= CNT_W'(INDEX_BITS - 1);
      fa      <= '0;
      fb      <= (n_in == '0) ? '0 : VALUE_BITS'(1);
      started <= 1'b0;
    end

    // doubling set-up: t = 2b - a
    if (state == ST_SCAN && started) begin
      tmp <= {fb[VALUE_BITS-2:0], 1'b0} - fa;
      op  <= OP_CROSS;
      dig <= '0;
      acc <= '0;
    end

    // doubling products: F(2k) = a(2b - a), F(2k+1) = a^2 + b^2
    if (state == ST_DBL) begin
      if (!mul_last) begin
        dig <= dig + DIG_W'(1);
        acc <= sum;
      end else begin
        dig <= '0;
        case (op)
          OP_CROSS: begin
            s1  <= sum;
            acc <= '0;
            op  <= OP_SQ_A;
          end
          OP_SQ_A: begin
            acc <= sum;
            op  <= OP_SQ_B;
          end
          default: begin
            fa <= s1;
            fb <= sum;
          end
        endcase
      end
    end

    // set bit: (a, b) -> (b, a + b)
    if (state == ST_ADV) begin
      fa      <= fb;
      fb      <= fa + fb;
      started <= 1'b1;
    end

    // next index bit
    if (step_adv && !last_bit) begin
      e   <= {e[INDEX_BITS-2:0], 1'b0};
      cnt <= cnt - CNT_W'(1);
    end
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for fibonacci_matrix_power: directed indices, then
// random ones, each result checked in order against a table value or a local
// matrix power predictor, with random gaps on both stream channels
// ----------------------------------------------------------------------------
module tb;

  import fmp_pkg::*;

  localparam int N_DIRECTED  = 20;
  localparam int N_RANDOM    = 1800;
  localparam int N_TOTAL     = N_DIRECTED + N_RANDOM;
  localparam int DRAIN       = 400;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [FIB_W-1:0] a;
    logic [FIB_W-1:0] b;
    logic [FIB_W-1:0] c;
    logic [FIB_W-1:0] d;
  } mat2_t;

  // one row of the directed table; typed marks an expected value given here
  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic               typed;
    logic [FIB_W-1:0]   fib;
  } index_row_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [FIB_W-1:0]   fib;
  } fib_entry_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [30:0] index, [31] zero pad
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // [31:0] fib_value

  fib_entry_t expected_fib[$];
  int         errors = 0;
  int         cycle_count = 0;
  bit         no_idle = 1'b0;

  fibonacci_matrix_power u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock and reset
  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // 2x2 product, entries wrap to the value width
  function automatic mat2_t matrix_product(input mat2_t x, input mat2_t y);
    mat2_t r;
    r.a = x.a * y.a + x.b * y.c;
    r.b = x.a * y.b + x.b * y.d;
    r.c = x.c * y.a + x.d * y.c;
    r.d = x.c * y.b + x.d * y.d;
    return r;
  endfunction

  // top-left entry of [[1,1],[1,0]]^(n-1), scanning n-1 from the top bit
  function automatic logic [FIB_W-1:0] fib_by_matrix(input logic [INDEX_W-1:0] n);
    mat2_t              acc;
    mat2_t              q;
    logic [INDEX_W-1:0] e;
    acc = '{a: 1, b: 0, c: 0, d: 1};
    q   = '{a: 1, b: 1, c: 1, d: 0};
    if (n == '0) return '0;
    e = n - 1'b1;
    for (int i = INDEX_W - 1; i >= 0; i--) begin
      acc = matrix_product(acc, acc);
      if (e[i]) acc = matrix_product(acc, q);
    end
    return acc.a;
  endfunction

  // directed table: smallest indices, first signed wrap, bit patterns, maximum
  function automatic index_row_t stim_row(input int i);
    case (i)
      0:       return '{31'd0,          1'b1, 32'd0};
      1:       return '{31'd1,          1'b1, 32'd1};
      2:       return '{31'd2,          1'b1, 32'd1};
      3:       return '{31'd3,          1'b1, 32'd2};
      4:       return '{31'd10,         1'b1, 32'd55};
      5:       return '{31'd46,         1'b0, 32'd0};
      6:       return '{31'd47,         1'b0, 32'd0};
      7:       return '{31'd48,         1'b0, 32'd0};
      8:       return '{31'h7fffffff,   1'b0, 32'd0};
      9:       return '{31'h7ffffffe,   1'b0, 32'd0};
      10:      return '{31'h40000000,   1'b0, 32'd0};
      11:      return '{31'h40000001,   1'b0, 32'd0};
      12:      return '{31'h2aaaaaaa,   1'b0, 32'd0};
      13:      return '{31'h55555555,   1'b0, 32'd0};
      14:      return '{31'h00010000,   1'b0, 32'd0};
      15:      return '{31'h00010001,   1'b0, 32'd0};
      16:      return '{31'h12345678,   1'b0, 32'd0};
      17:      return '{31'd1000,       1'b0, 32'd0};
      18:      return '{31'd0,          1'b1, 32'd0};
      default: return '{31'd1,          1'b1, 32'd1};
    endcase
  endfunction

  // random index: small values, powers of two, runs of ones, full range
  function automatic logic [INDEX_W-1:0] draw_index();
    int unsigned r;
    int unsigned k;
    r = $urandom_range(0, 9);
    k = $urandom_range(0, INDEX_W - 1);
    case (r)
      0:       return INDEX_W'($urandom_range(0, 3));
      1, 2:    return INDEX_W'($urandom_range(0, 100));
      3:       return INDEX_W'((32'd1 << k) + $urandom_range(0, 2) - 32'd1);
      4:       return (31'd1 << k) - 1'b1;
      default: return INDEX_W'($urandom);
    endcase
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int idle_length();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 8) return 0;
    if (r < 14) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic report(input string what, input logic [INDEX_W-1:0] index,
                        input logic [FIB_W-1:0] got, input logic [FIB_W-1:0] want);
    $display("mismatch: %s index=%0d got=%0d want=%0d", what, index,
             $signed(got), $signed(want));
    errors++;
  endtask

  // slave side: drive one index per transaction and record its expected value
  initial begin : stimulus
    index_row_t row;
    int         gap;
    wait (!rst);
    @(posedge clk);
    for (int item = 0; item < N_TOTAL; item++) begin
      if (item < N_DIRECTED) row = stim_row(item);
      else row = '{draw_index(), 1'b0, 32'd0};
      no_idle = (item >= 600 && item < 800) || (item >= 1400 && item < 1500);
      gap = no_idle ? 0 : idle_length();
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= {1'b0, row.index};
      do @(posedge clk); while (!s_tready);
      expected_fib.push_back(fib_entry_t'{row.index,
                             row.typed ? row.fib : fib_by_matrix(row.index)});
    end
    s_tvalid <= 1'b0;
    while (expected_fib.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("fibonacci_matrix_power test passed");
    end else begin
      $display("fibonacci_matrix_power test failed");
    end
    $finish;
  end

  // master side back-pressure: ready bursts broken by random stalls
  initial begin : receiver
    int stall;
    wait (!rst);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : idle_length();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // result check, oldest expectation first
  always @(posedge clk) begin
    fib_entry_t head;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_fib.size() == 0) begin
        report("unexpected result", '0, m_tdata[FIB_W-1:0], '0);
      end else begin
        head = expected_fib.pop_front();
        if (m_tdata[FIB_W-1:0] !== head.fib)
          report("fib_value", head.index, m_tdata[FIB_W-1:0], head.fib);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("fibonacci_matrix_power test failed");
      $finish;
    end
  end

endmodule
